@@ src/pru_pkg.sv @@
// ----------------------------------------------------------------------------
// PNG row unfilter package
// Filter type codes and the Paeth predictor shared by the unfilter block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pru_pkg;

  // Row filter codes; codes above FILT_PAETH are invalid
  typedef enum logic [2:0] {
    FILT_NONE  = 3'd0,
    FILT_SUB   = 3'd1,
    FILT_UP    = 3'd2,
    FILT_AVG   = 3'd3,
    FILT_PAETH = 3'd4
  } filt_t;

  // Register indexes on the configuration port
  localparam logic REG_ROW_BYTES = 1'b0;
  localparam logic REG_BPP       = 1'b1;

  localparam int unsigned ROW_BYTES_W = 14;
  localparam int unsigned BPP_W       = 4;

  // Pick the neighbor closest to a + b - c; ties prefer a, then b
  function automatic logic [7:0] paeth_pick(input logic [7:0] a, input logic [7:0] b,
                                            input logic [7:0] c);
    logic signed [10:0] p;
    logic signed [10:0] da;
    logic signed [10:0] db;
    logic signed [10:0] dc;
    p  = $signed({3'b000, a}) + $signed({3'b000, b}) - $signed({3'b000, c});
    da = p - $signed({3'b000, a});
    db = p - $signed({3'b000, b});
    dc = p - $signed({3'b000, c});
    if (da < 0) da = -da;
    if (db < 0) db = -db;
    if (dc < 0) dc = -dc;
    if ((da <= db) && (da <= dc)) return a;
    if (db <= dc) return b;
    return c;
  endfunction

endpackage

`default_nettype wire

@@ src/pru_ram.sv @@
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port, one read port with registered, read-first data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pru_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8192
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

@@ src/png_row_unfilter_top.sv @@
// ----------------------------------------------------------------------------
// PNG scanline unfilter
// Rebuilds raw scanline bytes from filtered bytes (none, sub, up, average,
// Paeth) using a previous-row RAM and short left / upper-left histories.
// ----------------------------------------------------------------------------
// Pipeline: an accepted byte is registered in stage 1 and then in the output
//   register, from which it is presented on out_*.
// Throughput: one byte per cycle unless out_tready stalls; the rebuild stage
//   reads the previous-row RAM output and writes the result back the same cycle.
// Reset (rst_n low, synchronous): empties the pipeline, clears the column and
//   both histories, and sets row_bytes and bytes_per_pixel to 1. The previous-row
//   RAM is not cleared; the first row must be flagged with first_row.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module png_row_unfilter_top
  import pru_pkg::*;
#(
  parameter int unsigned MAX_ROW_BYTES       = 8192,
  parameter int unsigned MAX_BYTES_PER_PIXEL = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,     // [7:0] filtered_byte
  input  wire logic [3:0]  in_tuser,     // [2:0] filter_type, [3] first_row
  // Result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,    // [7:0] pixel_byte
  output logic             out_tlast,    // end_of_row
  output logic [0:0]       out_tuser,    // [0] bad_filter
  // Configuration (APB style)
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  localparam int unsigned CW   = $clog2(MAX_ROW_BYTES);
  localparam int unsigned HW   = (MAX_BYTES_PER_PIXEL > 1) ? $clog2(MAX_BYTES_PER_PIXEL) : 1;
  localparam int unsigned CMPW = (CW + 1 > ROW_BYTES_W) ? CW + 1 : ROW_BYTES_W;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [ROW_BYTES_W-1:0] row_bytes_r;
  logic [BPP_W-1:0]       bpp_r;
  logic                   cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_bytes_r <= ROW_BYTES_W'(1);
      bpp_r       <= BPP_W'(1);
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == REG_ROW_BYTES) begin
        row_bytes_r <= cfg_pwdata[ROW_BYTES_W-1:0];
      end else begin
        bpp_r <= cfg_pwdata[BPP_W-1:0];
      end
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == REG_BPP) ? 32'(bpp_r) : 32'(row_bytes_r);

  // Clamp the registers to the range the datapath supports
  logic [CMPW-1:0]  rb_eff;
  logic [BPP_W-1:0] bpp_eff;
  logic [HW-1:0]    hist_idx;

  always_comb begin
    rb_eff = CMPW'(row_bytes_r);
    if (rb_eff == '0) begin
      rb_eff = CMPW'(1);
    end else if (rb_eff > CMPW'(MAX_ROW_BYTES)) begin
      rb_eff = CMPW'(MAX_ROW_BYTES);
    end
    bpp_eff = bpp_r;
    if (bpp_eff == '0) begin
      bpp_eff = BPP_W'(1);
    end else if (bpp_eff > BPP_W'(MAX_BYTES_PER_PIXEL)) begin
      bpp_eff = BPP_W'(MAX_BYTES_PER_PIXEL);
    end
  end

  assign hist_idx = HW'(bpp_eff - BPP_W'(1));

  // --------------------------------------------------------------------------
  // Handshake: stage 1 holds the byte being rebuilt, the output register holds
  // the finished byte. Stage 1 drains whenever the output register is free or
  // being emptied, so a new byte enters in the same cycle.
  // --------------------------------------------------------------------------
  logic s1_valid_r;
  logic out_valid_r;
  logic out_free;
  logic s1_adv;
  logic in_acc;

  assign out_free  = !out_valid_r || out_tready;
  assign s1_adv    = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || out_free;
  assign in_acc    = in_tvalid && in_tready;

  // --------------------------------------------------------------------------
  // Stage 0: column tracking and previous-row RAM read
  // --------------------------------------------------------------------------
  logic [CW-1:0] col_r;
  logic [CW-1:0] col_nxt;
  logic          row_end;
  logic          has_left;

  assign row_end  = (CMPW'(col_r) + CMPW'(1)) >= rb_eff;
  assign has_left = CMPW'(col_r) >= CMPW'(bpp_eff);
  assign col_nxt  = row_end ? '0 : col_r + CW'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
    end else if (in_acc) begin
      col_r <= col_nxt;
    end
  end

  logic [CW-1:0] s1_col_r;
  logic [7:0]    s1_byte_r;
  logic [2:0]    s1_ftype_r;
  logic          s1_first_r;
  logic          s1_left_r;
  logic          s1_last_r;
  logic          fwd_hit_r;
  logic [7:0]    fwd_data_r;
  logic [7:0]    result;
  logic [7:0]    ram_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  // Capture the byte and its context; forward a write that lands on the same
  // column in the same cycle, since the RAM returns the old data then.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_col_r   <= col_r;
      s1_byte_r  <= in_tdata;
      s1_ftype_r <= in_tuser[2:0];
      s1_first_r <= in_tuser[3];
      s1_left_r  <= has_left;
      s1_last_r  <= row_end;
      fwd_hit_r  <= s1_adv && (s1_col_r == col_r);
      fwd_data_r <= result;
    end
  end

  pru_ram #(
    .WIDTH (8),
    .DEPTH (MAX_ROW_BYTES)
  ) u_prev_row (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_col_r),
    .wdata (result),
    .re    (in_acc),
    .raddr (col_r),
    .rdata (ram_rdata)
  );

  // --------------------------------------------------------------------------
  // Stage 1: predict and rebuild
  // --------------------------------------------------------------------------
  logic [7:0] left_hist_r [MAX_BYTES_PER_PIXEL];
  logic [7:0] upleft_hist_r [MAX_BYTES_PER_PIXEL];
  logic [7:0] nb_a;
  logic [7:0] nb_b;
  logic [7:0] nb_c;
  logic [7:0] pred;
  logic [8:0] ab_sum;
  logic       bad;

  always_comb begin
    nb_b   = s1_first_r ? 8'h00 : (fwd_hit_r ? fwd_data_r : ram_rdata);
    nb_a   = s1_left_r ? left_hist_r[hist_idx] : 8'h00;
    nb_c   = s1_left_r ? upleft_hist_r[hist_idx] : 8'h00;
    ab_sum = {1'b0, nb_a} + {1'b0, nb_b};
    bad    = 1'b0;
    unique case (s1_ftype_r)
      FILT_NONE:  pred = 8'h00;
      FILT_SUB:   pred = nb_a;
      FILT_UP:    pred = nb_b;
      FILT_AVG:   pred = ab_sum[8:1];
      FILT_PAETH: pred = paeth_pick(nb_a, nb_b, nb_c);
      default: begin
        pred = 8'h00;
        bad  = 1'b1;
      end
    endcase
    result = bad ? 8'h00 : s1_byte_r + pred;
  end

  // Shift both histories once per rebuilt byte, across row boundaries too
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < MAX_BYTES_PER_PIXEL; k++) begin
        left_hist_r[k]   <= 8'h00;
        upleft_hist_r[k] <= 8'h00;
      end
    end else if (s1_adv) begin
      for (int k = MAX_BYTES_PER_PIXEL - 1; k > 0; k--) begin
        left_hist_r[k]   <= left_hist_r[k-1];
        upleft_hist_r[k] <= upleft_hist_r[k-1];
      end
      left_hist_r[0]   <= result;
      upleft_hist_r[0] <= nb_b;
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  logic [7:0] out_byte_r;
  logic       out_last_r;
  logic       out_bad_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_byte_r <= result;
      out_last_r <= s1_last_r;
      out_bad_r  <= bad;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_byte_r;
  assign out_tlast    = out_last_r;
  assign out_tuser[0] = out_bad_r;

endmodule

`default_nettype wire

@@ src/pru_checker.sv @@
// ----------------------------------------------------------------------------
// PNG row unfilter port checker
// Watches the top-level ports for stall, backpressure and error behavior.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pru_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_tready,
  input wire logic       out_tvalid,
  input wire logic       out_tready,
  input wire logic [7:0] out_tdata,
  input wire logic       out_tlast,
  input wire logic [0:0] out_tuser
);

  // Output is empty right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

  // A stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=>
      out_tvalid && $stable(out_tdata) && $stable(out_tlast) && $stable(out_tuser))
    else $error("stalled result changed");

  // Input backpressure only comes from a stalled, full output
  a_bp_source: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled without output backpressure");

  // An invalid filter type yields a zero byte
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata == 8'h00)
    else $error("bad filter result not zero");

endmodule

bind png_row_unfilter_top pru_checker u_pru_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);

`default_nettype wire
